// ----- hdl/gsa_pkg.sv -----
package gsa_pkg;

  // Table geometry.
  localparam int SLOTS    = 64;
  localparam int GEN_BITS = 16;
  localparam int SLOT_W   = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);

  // Stream payload widths.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // Command codes.
  localparam logic [1:0] CMD_CREATE  = 2'd0;
  localparam logic [1:0] CMD_DESTROY = 2'd1;
  localparam logic [1:0] CMD_CHECK   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_FREE    = 2'd1;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;  // capture the input transfer and start the stack read
    logic fetch;  // resolve the slot and start the generation read
    logic exec;   // update state and load the result register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;  // a result is held and not taken this cycle
  } dp_stat_t;

endpackage

// ----- hdl/generational_slot_allocator.sv -----
// Flow: a command accepted in S_IDLE has its slot resolved in S_FETCH and its
// result loaded onto out_tvalid in S_EXEC, which waits while the output side is stalled.
// A new command is taken only once the last one has executed, as set by the two dependent
// registered memory reads (free stack top, then slot generation).
// Reset (rst_n low, synchronous): slots 0 to SLOTS-2 are free with slot 0 on top,
// all generations read as one, no slot is active; there is no clearing pass.
module generational_slot_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [1:0] command, [9:2] handle_index, [25:10] handle_generation, [31:26] zero
  input  logic [gsa_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [5:0] result_index, [21:6] result_generation, [23:22] status,
  // [30:24] live_count, [31] zero
  output logic [gsa_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import gsa_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gsa_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- hdl/gsa_ctrl.sv -----
module gsa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  gsa_pkg::dp_stat_t stat,
  output gsa_pkg::ctl_cmd_t cmd
);
  import gsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.out_blocked) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command decode.
  assign in_tready = (state_r == S_IDLE);
  assign cmd.latch = (state_r == S_IDLE) && in_tvalid;
  assign cmd.fetch = (state_r == S_FETCH);
  assign cmd.exec  = (state_r == S_EXEC) && !stat.out_blocked;

endmodule

// ----- hdl/gsa_dp.sv -----
module gsa_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gsa_pkg::ctl_cmd_t                 cmd,
  output gsa_pkg::dp_stat_t                 stat,
  input  logic [gsa_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gsa_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import gsa_pkg::*;

  // Captured command.
  logic [1:0]          cmd_r;
  logic [7:0]          idx_r;
  logic [15:0]         hgen_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOT_W-1:0]   slot_nxt;

  // Allocation state.
  logic [CNT_W-1:0]    depth_r;
  logic [CNT_W-1:0]    depth_nxt;
  logic [CNT_W-1:0]    total_r;
  logic [CNT_W-1:0]    total_nxt;
  logic [SLOTS-1:0]    active_r;

  // Free stack memory, its written marks and read port.
  logic [SLOT_W-1:0]   stack_mem [SLOTS];
  logic [SLOTS-1:0]    stack_v_r;
  logic [SLOT_W-1:0]   stack_rd_r;
  logic                stack_rd_v_r;
  logic [SLOT_W-1:0]   stack_raddr_r;
  logic [SLOT_W-1:0]   stack_raddr;
  logic [SLOT_W-1:0]   slot_pop;

  // Generation memory, its written marks and read port.
  logic [GEN_BITS-1:0] gen_mem [SLOTS];
  logic [SLOTS-1:0]    gen_v_r;
  logic [GEN_BITS-1:0] gen_rd_r;
  logic                gen_rd_v_r;
  logic [GEN_BITS-1:0] gen_cur;

  // Decisions of the execute step.
  logic                in_range;
  logic                handle_ok;
  logic                create_ok;
  logic                destroy_ok;
  logic                stack_we;
  logic                gen_we;

  // Result register.
  logic                out_valid_r;
  logic [SLOT_W-1:0]   res_index_r;
  logic [SLOT_W-1:0]   res_index_nxt;
  logic [15:0]         res_gen_r;
  logic [15:0]         res_gen_nxt;
  logic [1:0]          res_status_r;
  logic [1:0]          res_status_nxt;
  logic [CNT_W-1:0]    res_live_r;

  // The stack top is read while the command is captured.
  assign stack_raddr = SLOT_W'(depth_r - CNT_W'(1));

  // An unwritten stack entry holds its reset contents.
  assign slot_pop = stack_rd_v_r ? stack_rd_r
                                 : (SLOT_W'(SLOTS - 2) - stack_raddr_r);
  assign slot_nxt = (cmd_r == CMD_CREATE) ? slot_pop : idx_r[SLOT_W-1:0];

  // An unwritten generation entry reads as one.
  assign gen_cur = gen_rd_v_r ? gen_rd_r : GEN_BITS'(1);

  // Handle and command checks.
  assign in_range   = (32'(idx_r) < SLOTS);
  assign handle_ok  = in_range && active_r[slot_r] && (GEN_BITS'(hgen_r) == gen_cur);
  assign create_ok  = (cmd_r == CMD_CREATE) && (depth_r != '0);
  assign destroy_ok = (cmd_r == CMD_DESTROY) && handle_ok;
  assign stack_we   = cmd.exec && destroy_ok && (32'(depth_r) < SLOTS);
  assign gen_we     = cmd.exec && destroy_ok;

  // Result fields and counter updates.
  always_comb begin
    res_index_nxt  = idx_r[SLOT_W-1:0];
    res_gen_nxt    = '0;
    res_status_nxt = ST_BAD_HANDLE;
    depth_nxt      = depth_r;
    total_nxt      = total_r;
    case (cmd_r)
      CMD_CREATE: begin
        if (create_ok) begin
          res_index_nxt  = slot_r;
          res_gen_nxt    = 16'(gen_cur);
          res_status_nxt = ST_OK;
          depth_nxt      = depth_r - CNT_W'(1);
          total_nxt      = total_r + CNT_W'(1);
        end else begin
          res_index_nxt  = '0;
          res_status_nxt = ST_NO_FREE;
        end
      end
      CMD_DESTROY: begin
        if (handle_ok) begin
          res_status_nxt = ST_OK;
          if (32'(depth_r) < SLOTS) begin
            depth_nxt = depth_r + CNT_W'(1);
          end
          if (total_r != '0) begin
            total_nxt = total_r - CNT_W'(1);
          end
        end
      end
      CMD_CHECK: begin
        res_status_nxt = handle_ok ? ST_OK : ST_BAD_HANDLE;
      end
      default: begin
        res_status_nxt = ST_BAD_HANDLE;
      end
    endcase
  end

  // Command capture and slot selection.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= in_tdata[1:0];
      idx_r  <= in_tdata[9:2];
      hgen_r <= in_tdata[25:10];
    end
    if (cmd.fetch) begin
      slot_r <= slot_nxt;
    end
  end

  // Memory arrays: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[depth_r[SLOT_W-1:0]] <= slot_r;
    end
    if (cmd.latch) begin
      stack_rd_r    <= stack_mem[stack_raddr];
      stack_rd_v_r  <= stack_v_r[stack_raddr];
      stack_raddr_r <= stack_raddr;
    end
    if (gen_we) begin
      gen_mem[slot_r] <= gen_cur + GEN_BITS'(1);
    end
    if (cmd.fetch) begin
      gen_rd_r   <= gen_mem[slot_nxt];
      gen_rd_v_r <= gen_v_r[slot_nxt];
    end
  end

  // Control state, written marks and active bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r   <= CNT_W'(SLOTS - 1);
      total_r   <= '0;
      active_r  <= '0;
      stack_v_r <= '0;
      gen_v_r   <= '0;
    end else if (cmd.exec) begin
      depth_r <= depth_nxt;
      total_r <= total_nxt;
      if (create_ok) begin
        active_r[slot_r] <= 1'b1;
      end
      if (destroy_ok) begin
        active_r[slot_r] <= 1'b0;
        gen_v_r[slot_r]  <= 1'b1;
      end
      if (stack_we) begin
        stack_v_r[depth_r[SLOT_W-1:0]] <= 1'b1;
      end
    end
  end

  // Result register: loaded on execute, freed by the output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_index_r  <= res_index_nxt;
      res_gen_r    <= res_gen_nxt;
      res_status_r <= res_status_nxt;
      res_live_r   <= total_nxt;
    end
  end

  assign stat.out_blocked = out_valid_r && !out_tready;
  assign out_tvalid       = out_valid_r;
  assign out_tdata        = {1'b0, res_live_r, res_status_r, res_gen_r, res_index_r};

`ifndef SYNTHESIS
  // Every slot but the last is either free or active.
  a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(depth_r) + 32'(total_r)) == (SLOTS - 1))
    else $error("free depth plus live count lost a slot");

  // A successful create leaves its slot active.
  a_create_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && create_ok) |=> active_r[$past(slot_r)])
    else $error("created slot not marked active");

  // A successful destroy leaves its slot inactive.
  a_destroy_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && destroy_ok) |=> !active_r[$past(slot_r)])
    else $error("destroyed slot still active");

  // A result is never loaded over one that is still held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> !(out_valid_r && !out_tready))
    else $error("result register overwritten");
`endif

endmodule
